FILE: rtl/core/seam_line_overlap_select_assert.svh
// Assertion macros for the seam line overlap selector; they expect clk and rst in scope.
`ifndef SEAM_LINE_OVERLAP_SELECT_ASSERT_SVH
`define SEAM_LINE_OVERLAP_SELECT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLOS_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("seam select: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SLOS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("seam select: next-cycle check failed");

`endif

FILE: rtl/core/slos_pkg.sv
// Shared types and constants of the seam line overlap selector.
`default_nettype none

package slos_pkg;

  localparam int MAX_WIDTH_DEFAULT = 2048;
  localparam int COST_BITS_DEFAULT = 32;
  localparam int WIDTH_REG_BITS    = 12;
  localparam int WIDTH_RESET       = 2048;
  localparam int MIN_WIDTH         = 2;
  localparam int CHAN_BITS         = 8;
  localparam int SEAM_BITS         = 11;
  localparam int PIX_BITS          = 6 * CHAN_BITS;
  localparam int SQ_BITS           = 2 * CHAN_BITS;
  localparam int DIFF_SUM_BITS     = SQ_BITS + 2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [CHAN_BITS-1:0] blue_first;
    logic [CHAN_BITS-1:0] green_first;
    logic [CHAN_BITS-1:0] red_first;
    logic [CHAN_BITS-1:0] blue_second;
    logic [CHAN_BITS-1:0] green_second;
    logic [CHAN_BITS-1:0] red_second;
  } slos_in_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] out_blue;
    logic [CHAN_BITS-1:0] out_green;
    logic [CHAN_BITS-1:0] out_red;
    logic                 from_second;
    logic [SEAM_BITS-1:0] seam_column;
    logic                 row_end;
  } slos_out_t;

  // Per-transaction control handed to the cost path together with the column.
  typedef struct packed {
    logic is_pixel;
    logic first_row;
    logic first_col;
    logic last_col;
  } slos_cost_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/slos_cost_path.sv
// Accumulated cost path: cost line store, forwarding, neighbour minimum and saturating add.
`default_nettype none

module slos_cost_path import slos_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  parameter int COST_BITS = COST_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         issue,
  input  logic [$clog2(MAX_WIDTH)-1:0] col,
  input  slos_cost_ctl_t               ctl,
  input  slos_in_t                     pair,
  output logic [COST_BITS-1:0]         acc_q
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int SUM_BITS = COST_BITS + 1;
  localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

  logic [COST_BITS-1:0] cost_mem [MAX_WIDTH];

  logic [CHAN_BITS-1:0] diff_b, diff_g, diff_r;
  logic [SQ_BITS-1:0]   sq_b, sq_g, sq_r;
  logic [SQ_BITS-1:0]   s1_sq_b, s1_sq_g, s1_sq_r;

  logic                 s1_valid;
  slos_cost_ctl_t       s1_ctl;
  logic [COL_BITS-1:0]  s1_col_a;
  logic [COL_BITS-1:0]  s1_col_b;
  logic [COST_BITS-1:0] rd_a, rd_b;

  logic                 fwd_valid;
  logic [COL_BITS-1:0]  fwd_addr;
  logic [COST_BITS-1:0] fwd_data;

  logic [COST_BITS-1:0] left_old_cost;
  logic [COST_BITS-1:0] cur_a, cur_b;
  logic [COST_BITS-1:0] min_ab, min_la, min_3, nb;
  logic [DIFF_SUM_BITS-1:0] d;
  logic [SUM_BITS-1:0]  sum;
  logic [COST_BITS-1:0] acc;
  logic                 wr_en;

  always_comb begin
    diff_b = (pair.blue_first > pair.blue_second) ? pair.blue_first - pair.blue_second
                                                  : pair.blue_second - pair.blue_first;
    diff_g = (pair.green_first > pair.green_second) ? pair.green_first - pair.green_second
                                                    : pair.green_second - pair.green_first;
    diff_r = (pair.red_first > pair.red_second) ? pair.red_first - pair.red_second
                                                : pair.red_second - pair.red_first;
    sq_b = SQ_BITS'(diff_b) * SQ_BITS'(diff_b);
    sq_g = SQ_BITS'(diff_g) * SQ_BITS'(diff_g);
    sq_r = SQ_BITS'(diff_r) * SQ_BITS'(diff_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && issue) begin
      s1_ctl   <= ctl;
      s1_col_a <= col;
      s1_col_b <= col + COL_BITS'(1);
      s1_sq_b  <= sq_b;
      s1_sq_g  <= sq_g;
      s1_sq_r  <= sq_r;
    end
  end

  // Two reads at acceptance, one write from the accumulate stage.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_a <= cost_mem[col];
      rd_b <= cost_mem[col + COL_BITS'(1)];
    end
    if (wr_en) begin
      cost_mem[s1_col_a] <= acc;
    end
  end

  assign wr_en = advance && s1_valid && s1_ctl.is_pixel;

  // The forwarding register always holds the most recent write, so a match
  // returns what the store holds now even when the read saw older data.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= s1_col_a;
      fwd_data <= acc;
    end
  end

  always_comb begin
    cur_a  = (fwd_valid && fwd_addr == s1_col_a) ? fwd_data : rd_a;
    cur_b  = (fwd_valid && fwd_addr == s1_col_b) ? fwd_data : rd_b;
    min_ab = (cur_a < cur_b) ? cur_a : cur_b;
    min_la = (left_old_cost < cur_a) ? left_old_cost : cur_a;
    min_3  = (min_la < cur_b) ? min_la : cur_b;
    if (s1_ctl.first_col) begin
      nb = min_ab;
    end else if (s1_ctl.last_col) begin
      nb = min_la;
    end else begin
      nb = min_3;
    end
    d   = DIFF_SUM_BITS'(s1_sq_b) + DIFF_SUM_BITS'(s1_sq_g) + DIFF_SUM_BITS'(s1_sq_r);
    sum = {1'b0, nb} + SUM_BITS'(d);
    if (s1_ctl.first_row) begin
      acc = COST_BITS'(d);
    end else if (sum[COST_BITS]) begin
      acc = COST_MAX;
    end else begin
      acc = sum[COST_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_old_cost <= '0;
    end else if (advance && s1_valid) begin
      left_old_cost <= cur_a;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      acc_q <= acc;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/seam_line_overlap_select.sv
// Top level of the seam line overlap selector: control, pixel line store, seam search, output.
//
// Pixel pairs of the overlap strip enter on the input channel (in_valid, in_stall, in_data) in
// raster order; a transaction with op set to drain flushes one pixel of the buffered row.
// Composited pixels leave on the output channel (out_valid, out_stall, out_data), one row behind
// the input, with the seam column of that row and a row end flag on its last pixel.
// The strip width is written on the cfg channel (cfg_valid, cfg_ready, cfg_data); the user must
// write it only while idle, which the block does not enforce. cfg_ready is always high and the
// width is clamped to the supported range when written. An item is accepted into stage s1, its
// costs are accumulated into stage s2, and its result, if any, then enters the output register.
// One item is taken every cycle while in_stall is low. The pixel line store is read and written
// at acceptance and the cost line store is read on two ports at acceptance and written from the
// accumulate stage, with a forwarding register covering a read of the entry written on the same
// edge. Reset empties the pipeline, sets the width to 2048 and starts a new frame; the line stores
// are not cleared. When the receiver stalls while a result is held, only an item that has a result
// waiting to enter the output register stops the pipeline, and in_stall follows it.
`default_nettype none

module seam_line_overlap_select import slos_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  parameter int COST_BITS = COST_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  slos_in_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output slos_out_t                 out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [WIDTH_REG_BITS-1:0] cfg_data
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int CW = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_BITS) ? $clog2(MAX_WIDTH + 1)
                                                              : WIDTH_REG_BITS;
  localparam int RESET_USED_WIDTH = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

  logic [PIX_BITS-1:0] pixel_mem [MAX_WIDTH];

  logic [CW-1:0]        used_width;
  logic [CW-1:0]        cfg_ext;
  logic [COL_BITS-1:0]  column_count;
  logic                 first_row_flag;
  logic                 row_buffered;
  logic [CW-1:0]        col_inc;
  logic                 last;
  logic                 accept;
  logic                 is_drain;
  logic                 live;
  logic                 advance;
  slos_cost_ctl_t       cost_ctl;
  logic [COST_BITS-1:0] cost_acc;

  logic [PIX_BITS-1:0]  pix_rd;
  logic                 s1_valid, s1_emit, s1_last, s1_drain;
  logic [COL_BITS-1:0]  s1_col;
  logic                 s2_valid, s2_emit, s2_last, s2_drain;
  logic [COL_BITS-1:0]  s2_col;
  logic [PIX_BITS-1:0]  s2_pix;

  logic [COST_BITS-1:0] running_min_cost;
  logic [COL_BITS-1:0]  running_min_column;
  logic [COL_BITS-1:0]  buffered_seam;
  logic                 take_min;
  logic [COL_BITS-1:0]  min_column_next;
  logic                 s2_second;
  logic [3*CHAN_BITS-1:0] s2_chosen;

  // Configuration: the width is clamped once, at the write.
  assign cfg_ready = 1'b1;
  assign cfg_ext   = CW'(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      used_width <= CW'(RESET_USED_WIDTH);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_ext < CW'(MIN_WIDTH)) begin
        used_width <= CW'(MIN_WIDTH);
      end else if (cfg_ext > CW'(MAX_WIDTH)) begin
        used_width <= CW'(MAX_WIDTH);
      end else begin
        used_width <= cfg_ext;
      end
    end
  end

  // Only an emitting item that cannot enter a full, stalled output register holds things up.
  assign advance  = !(s2_valid && s2_emit && out_valid && out_stall);
  assign in_stall = !advance;

  assign accept   = in_valid && !in_stall;
  assign is_drain = (in_data.op == OP_DRAIN);
  assign live     = accept && !(is_drain && !row_buffered);
  assign col_inc  = CW'(column_count) + CW'(1);
  assign last     = (col_inc >= used_width);

  always_comb begin
    cost_ctl.is_pixel  = !is_drain;
    cost_ctl.first_row = first_row_flag;
    cost_ctl.first_col = (column_count == '0);
    cost_ctl.last_col  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= '0;
      first_row_flag <= 1'b1;
      row_buffered   <= 1'b0;
    end else if (live) begin
      if (last) begin
        column_count   <= '0;
        row_buffered   <= !is_drain;
        first_row_flag <= is_drain;
      end else begin
        column_count <= COL_BITS'(col_inc);
      end
    end
  end

  // Read returns the previous row's pair at this column before the new pair lands.
  always_ff @(posedge clk) begin
    if (live) begin
      pix_rd <= pixel_mem[column_count];
      if (!is_drain) begin
        pixel_mem[column_count] <= {in_data.red_second, in_data.green_second,
                                    in_data.blue_second, in_data.red_first,
                                    in_data.green_first, in_data.blue_first};
      end
    end
  end

  slos_cost_path #(
    .MAX_WIDTH (MAX_WIDTH),
    .COST_BITS (COST_BITS)
  ) u_cost (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .issue   (live),
    .col     (column_count),
    .ctl     (cost_ctl),
    .pair    (in_data),
    .acc_q   (cost_acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= live;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (live) begin
        s1_emit  <= row_buffered;
        s1_last  <= last;
        s1_drain <= is_drain;
        s1_col   <= column_count;
      end
      if (s1_valid) begin
        s2_emit  <= s1_emit;
        s2_last  <= s1_last;
        s2_drain <= s1_drain;
        s2_col   <= s1_col;
        s2_pix   <= pix_rd;
      end
    end
  end

  // Seam search: ties move the seam right, so the last column with the minimum wins.
  assign take_min        = (cost_acc <= running_min_cost);
  assign min_column_next = take_min ? s2_col : running_min_column;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_min_cost   <= COST_MAX;
      running_min_column <= '0;
      buffered_seam      <= '0;
    end else if (advance && s2_valid) begin
      if (s2_drain) begin
        if (s2_last) begin
          running_min_cost   <= COST_MAX;
          running_min_column <= '0;
        end
      end else if (s2_last) begin
        buffered_seam      <= min_column_next;
        running_min_cost   <= COST_MAX;
        running_min_column <= '0;
      end else begin
        running_min_cost   <= take_min ? cost_acc : running_min_cost;
        running_min_column <= min_column_next;
      end
    end
  end

  assign s2_second = (s2_col >= buffered_seam);
  assign s2_chosen = s2_second ? s2_pix[PIX_BITS-1 -: 3*CHAN_BITS]
                               : s2_pix[3*CHAN_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s2_valid && s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data.out_blue    <= s2_chosen[CHAN_BITS-1:0];
      out_data.out_green   <= s2_chosen[2*CHAN_BITS-1:CHAN_BITS];
      out_data.out_red     <= s2_chosen[3*CHAN_BITS-1:2*CHAN_BITS];
      out_data.from_second <= s2_second;
      out_data.seam_column <= SEAM_BITS'(buffered_seam);
      out_data.row_end     <= s2_last;
    end
  end

`include "seam_line_overlap_select_assert.svh"

  // Input back-pressure only ever comes from a held, stalled result.
  `SLOS_ASSERT_SAME(a_stall_source, in_stall, out_valid && out_stall)
  // After any item that takes effect the column stays inside the row in use.
  `SLOS_ASSERT_NEXT(a_column_in_row, live, CW'(column_count) < used_width)
  // A frozen pipeline keeps its emitting item until the output register frees up.
  `SLOS_ASSERT_NEXT(a_hold_result, s2_valid && s2_emit && !advance, s2_valid && s2_emit)

endmodule

`default_nettype wire
